/* hw/rtl/mhtq_pkg.sv */
package mhtq_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CHILD_W     = IDX_W + 2;
  localparam int MAX_RESULTS = 64;
  localparam int RIDX_W      = $clog2(MAX_RESULTS);
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 48;

  typedef logic [1:0] func_t;
  localparam func_t FN_ADD    = 2'd0;
  localparam func_t FN_CANCEL = 2'd1;
  localparam func_t FN_TICK   = 2'd2;
  localparam func_t FN_CLEAR  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_CANCELLED = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_EXPIRED   = 3'd4;
  localparam status_t ST_NONE_DUE  = 3'd5;
  localparam status_t ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [31:0]       ident;
    logic              cancelled;
  } entry_t;

endpackage

/* hw/rtl/min_heap_timer_queue.sv */
// timer queue kept as a binary min-heap in one synchronous ram, ordered by
// expiry and then by id; a millisecond counter advanced by each tick is the clock
// request channel: start/busy with in_func, in_delay, in_cancel_id; a request
// is taken on a clock edge with start high and busy low
// functions: add (returns new id), cancel (lazy mark), tick (advance 1 ms and
// report due ids), clear
// result channel: out_valid strobes each result for exactly one cycle with
// out_status, out_timer_id, out_head_changed, out_next_timeout, out_last;
// the receiver cannot stall
// sift-up and sift-down move one heap level per step through the single read
// port of the heap ram; an add also drops any cancelled timers from the top,
// a cancel spends most of its time in its scan over the heap, and a tick
// removes expired and cancelled timers from the top one at a time;
// busy drops as the last result is presented
// reset: synchronous active-low, empties the heap, clock to zero, next id one;
// the ram itself is not cleared, only entries below the count are used
module min_heap_timer_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mhtq_pkg::func_t      in_func,
  input  logic signed [31:0]   in_delay,
  input  logic [31:0]          in_cancel_id,
  output logic                 out_valid,
  output mhtq_pkg::status_t    out_status,
  output logic [31:0]          out_timer_id,
  output logic                 out_head_changed,
  output logic signed [31:0]   out_next_timeout,
  output logic                 out_last
);
  import mhtq_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_TOP_RD   = 15'b000000000000010,
    S_TOP_CHK  = 15'b000000000000100,
    S_CONT     = 15'b000000000001000,
    S_POP_RD   = 15'b000000000010000,
    S_POP_LAST = 15'b000000000100000,
    S_SD_L     = 15'b000000001000000,
    S_SD_R     = 15'b000000010000000,
    S_SD_CMP   = 15'b000000100000000,
    S_SU_CHK   = 15'b000001000000000,
    S_SU_CMP   = 15'b000010000000000,
    S_CAN      = 15'b000100000000000,
    S_DONE     = 15'b001000000000000,
    S_EMIT_RD  = 15'b010000000000000,
    S_EMIT_OUT = 15'b100000000000000
  } state_t;

  // heap ram and result id buffer
  entry_t      heap_mem [CAPACITY];
  entry_t      mem_q_r;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t      mem_wdata;

  logic [31:0] rbuf_mem [MAX_RESULTS];
  logic [31:0] rbuf_q_r;
  logic        rbuf_we;
  logic [RIDX_W-1:0] rbuf_waddr, rbuf_raddr;
  logic [31:0] rbuf_wdata;

  state_t state_r, state_nxt;
  func_t  op_r, op_nxt;
  logic   post_r, post_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [31:0]       idc_r, idc_nxt;
  entry_t top_r, top_nxt;
  entry_t cur_r, cur_nxt;
  entry_t lch_r, lch_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic   rok_r, rok_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic   pend_r, pend_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic   had_r, had_nxt;
  logic [31:0] oldtop_r, oldtop_nxt;
  logic [31:0] cid_r, cid_nxt;
  logic [TIME_W-1:0] newexp_r, newexp_nxt;
  status_t res_status_r, res_status_nxt;
  logic [31:0] res_id_r, res_id_nxt;
  logic   res_chg_r, res_chg_nxt;
  logic [RCNT_W-1:0] n_r, n_nxt;
  logic [RCNT_W-1:0] e_r, e_nxt;
  logic [31:0] nt_r, nt_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_id_r, out_id_nxt;
  logic        out_chg_r, out_chg_nxt;
  logic [31:0] out_nt_r, out_nt_nxt;
  logic        out_last_r, out_last_nxt;

  // child and parent positions
  logic [CHILD_W-1:0] lpos, rpos;
  logic [IDX_W-1:0]   parent;
  logic [TIME_W:0]    diff;
  logic               use_buf;
  logic [31:0]        idc_inc;

  function automatic logic earlier(entry_t a, entry_t b);
    logic res;
    if (a.expiry != b.expiry) begin
      res = a.expiry < b.expiry;
    end else begin
      res = a.ident < b.ident;
    end
    return res;
  endfunction

  assign lpos    = {1'b0, pos_r, 1'b1};
  assign rpos    = lpos + CHILD_W'(1);
  assign parent  = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign diff    = {1'b0, top_r.expiry} - {1'b0, now_r};
  assign use_buf = (op_r == FN_TICK) && (n_r != '0);
  assign idc_inc = idc_r + 32'd1;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    post_nxt       = post_r;
    count_nxt      = count_r;
    now_nxt        = now_r;
    idc_nxt        = idc_r;
    top_nxt        = top_r;
    cur_nxt        = cur_r;
    lch_nxt        = lch_r;
    pos_nxt        = pos_r;
    rok_nxt        = rok_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    had_nxt        = had_r;
    oldtop_nxt     = oldtop_r;
    cid_nxt        = cid_r;
    newexp_nxt     = newexp_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_chg_nxt    = res_chg_r;
    n_nxt          = n_r;
    e_nxt          = e_r;
    nt_nxt         = nt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_chg_nxt    = out_chg_r;
    out_nt_nxt     = out_nt_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = cur_r;
    mem_raddr      = '0;
    rbuf_we        = 1'b0;
    rbuf_waddr     = n_r[RIDX_W-1:0];
    rbuf_wdata     = top_r.ident;
    rbuf_raddr     = e_r[RIDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_func;
          res_id_nxt  = '0;
          res_chg_nxt = 1'b0;
          case (in_func)
            FN_ADD: begin
              post_nxt   = 1'b0;
              newexp_nxt = now_r + (in_delay[31] ? '0 : TIME_W'(in_delay[30:0]));
              state_nxt  = S_TOP_RD;
            end
            FN_CANCEL: begin
              post_nxt       = 1'b1;
              cid_nxt        = in_cancel_id;
              res_id_nxt     = in_cancel_id;
              res_status_nxt = ST_NOT_FOUND;
              k_nxt          = '0;
              pend_nxt       = 1'b0;
              state_nxt      = (in_cancel_id != '0) ? S_CAN : S_TOP_RD;
            end
            FN_TICK: begin
              post_nxt       = 1'b0;
              now_nxt        = now_r + TIME_W'(1);
              n_nxt          = '0;
              res_status_nxt = ST_NONE_DUE;
              state_nxt      = S_TOP_RD;
            end
            default: begin
              post_nxt       = 1'b1;
              count_nxt      = '0;
              res_status_nxt = ST_CLEARED;
              state_nxt      = S_TOP_RD;
            end
          endcase
        end
      end
      // prune loop: read the top, drop it while cancelled
      S_TOP_RD: begin
        mem_raddr = '0;
        state_nxt = S_TOP_CHK;
      end
      S_TOP_CHK: begin
        if ((count_r != '0) && mem_q_r.cancelled) begin
          state_nxt = S_POP_RD;
        end else begin
          top_nxt   = mem_q_r;
          state_nxt = S_CONT;
        end
      end
      S_CONT: begin
        state_nxt = S_DONE;
        if (!post_r) begin
          case (op_r)
            FN_ADD: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                had_nxt        = count_r != '0;
                oldtop_nxt     = top_r.ident;
                cur_nxt        = '{expiry: newexp_r, ident: idc_r, cancelled: 1'b0};
                pos_nxt        = count_r[IDX_W-1:0];
                count_nxt      = count_r + CNT_W'(1);
                idc_nxt        = (idc_inc == '0) ? 32'd1 : idc_inc;
                res_status_nxt = ST_ADDED;
                res_id_nxt     = idc_r;
                post_nxt       = 1'b1;
                state_nxt      = S_SU_CHK;
              end
            end
            FN_TICK: begin
              if ((count_r != '0) && (top_r.expiry <= now_r) &&
                  (n_r != RCNT_W'(MAX_RESULTS))) begin
                rbuf_we   = 1'b1;
                n_nxt     = n_r + RCNT_W'(1);
                state_nxt = S_POP_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // pop: move the last entry to the root and sift it down
      S_POP_RD: begin
        count_nxt = count_r - CNT_W'(1);
        mem_raddr = IDX_W'(count_r - CNT_W'(1));
        state_nxt = (count_r == CNT_W'(1)) ? S_TOP_RD : S_POP_LAST;
      end
      S_POP_LAST: begin
        cur_nxt   = mem_q_r;
        pos_nxt   = '0;
        state_nxt = S_SD_L;
      end
      S_SD_L: begin
        if (lpos >= CHILD_W'(count_r)) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          state_nxt = S_TOP_RD;
        end else begin
          mem_raddr = lpos[IDX_W-1:0];
          state_nxt = S_SD_R;
        end
      end
      S_SD_R: begin
        lch_nxt = mem_q_r;
        rok_nxt = rpos < CHILD_W'(count_r);
        mem_raddr = rpos[IDX_W-1:0];
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (rok_r && earlier(mem_q_r, lch_r) && earlier(mem_q_r, cur_r)) begin
          mem_wdata = mem_q_r;
          pos_nxt   = rpos[IDX_W-1:0];
          state_nxt = S_SD_L;
        end else if (earlier(lch_r, cur_r)) begin
          mem_wdata = lch_r;
          pos_nxt   = lpos[IDX_W-1:0];
          state_nxt = S_SD_L;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      // push: sift the new entry up from the end
      S_SU_CHK: begin
        if (pos_r == '0) begin
          mem_we      = 1'b1;
          mem_waddr   = '0;
          res_chg_nxt = !had_r || (cur_r.ident != oldtop_r);
          state_nxt   = S_TOP_RD;
        end else begin
          mem_raddr = parent;
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (earlier(cur_r, mem_q_r)) begin
          mem_wdata = mem_q_r;
          pos_nxt   = parent;
          state_nxt = S_SU_CHK;
        end else begin
          res_chg_nxt = !had_r;
          state_nxt   = S_TOP_RD;
        end
      end
      // cancel scan: read one entry a cycle, mark matches in the cycle after the read
      S_CAN: begin
        if (pend_r && (mem_q_r.ident == cid_r)) begin
          mem_we         = 1'b1;
          mem_waddr      = pidx_r;
          mem_wdata      = mem_q_r;
          mem_wdata.cancelled = 1'b1;
          res_status_nxt = ST_CANCELLED;
        end
        if (k_r < count_r) begin
          mem_raddr = k_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = k_r[IDX_W-1:0];
          k_nxt     = k_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_TOP_RD;
          end
        end
      end
      S_DONE: begin
        if (count_r == '0) begin
          nt_nxt = 32'hFFFF_FFFF;
        end else if (diff[TIME_W] || (diff == '0)) begin
          nt_nxt = '0;
        end else if (diff[TIME_W-1:31] != '0) begin
          nt_nxt = 32'h7FFF_FFFF;
        end else begin
          nt_nxt = {1'b0, diff[30:0]};
        end
        e_nxt     = '0;
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        out_valid_nxt = 1'b1;
        out_nt_nxt    = nt_r;
        if (use_buf) begin
          out_status_nxt = ST_EXPIRED;
          out_id_nxt     = rbuf_q_r;
          out_chg_nxt    = 1'b0;
          out_last_nxt   = e_r == (n_r - RCNT_W'(1));
        end else begin
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_chg_nxt    = res_chg_r;
          out_last_nxt   = 1'b1;
        end
        e_nxt     = e_r + RCNT_W'(1);
        state_nxt = out_last_nxt ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= heap_mem[mem_raddr];
    if (rbuf_we) begin
      rbuf_mem[rbuf_waddr] <= rbuf_wdata;
    end
    rbuf_q_r <= rbuf_mem[rbuf_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      now_r       <= '0;
      idc_r       <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      idc_r       <= idc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    post_r       <= post_nxt;
    top_r        <= top_nxt;
    cur_r        <= cur_nxt;
    lch_r        <= lch_nxt;
    pos_r        <= pos_nxt;
    rok_r        <= rok_nxt;
    k_r          <= k_nxt;
    pend_r       <= pend_nxt;
    pidx_r       <= pidx_nxt;
    had_r        <= had_nxt;
    oldtop_r     <= oldtop_nxt;
    cid_r        <= cid_nxt;
    newexp_r     <= newexp_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_chg_r    <= res_chg_nxt;
    n_r          <= n_nxt;
    e_r          <= e_nxt;
    nt_r         <= nt_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_chg_r    <= out_chg_nxt;
    out_nt_r     <= out_nt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_timer_id     = out_id_r;
  assign out_head_changed = out_chg_r;
  assign out_next_timeout = out_nt_r;
  assign out_last         = out_last_r;

  // heap never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // heap writes stay inside the live part of the heap
  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CNT_W'(mem_waddr) < count_r))
    else $error("heap write outside live entries");

  // result buffer never overflows
  a_rbuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rbuf_we |-> (n_r < RCNT_W'(MAX_RESULTS)))
    else $error("result buffer overflow");

  // the final result frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy after last result");

  // an accepted request always holds the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

endmodule
